// ===== hdl/tbfa_pkg.sv =====
// Shared types, constants and layout functions for the two-region bitmap allocator.
package tbfa_pkg;

  localparam int MAP_BYTES       = 512;
  localparam int INODES_IN_BLOCK = 16;
  localparam int MAP_AW          = $clog2(MAP_BYTES);
  localparam int PTR_W           = MAP_AW + 1;

  localparam int ITB_W      = 7;
  localparam int DBLK_W     = 12;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 12;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [ITB_W-1:0]  ITB_MIN  = 7'd1;
  localparam logic [ITB_W-1:0]  ITB_MAX  = 7'd64;
  localparam logic [DBLK_W-1:0] DBLK_MIN = 12'd4;
  localparam logic [DBLK_W-1:0] DBLK_MAX = 12'd3072;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 11'd2047;

  localparam logic [ITB_W-1:0]  RST_ITB  = 7'd1;
  localparam logic [DBLK_W-1:0] RST_DBLK = 12'd64;

  localparam logic [7:0] BYTE_FULL = 8'hFF;
  localparam logic [7:0] MSB_BIT   = 8'h80;

  typedef enum logic [OP_W-1:0] {
    OP_GRAB_INODE = 3'd0,
    OP_GRAB_DATA  = 3'd1,
    OP_FREE_INODE = 3'd2,
    OP_FREE_DATA  = 3'd3,
    OP_FORMAT     = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITB  = 1'd0,
    CFG_DBLK = 1'd1
  } cfg_idx_t;

  // Region layout derived from the configuration registers
  typedef struct packed {
    logic              ok;
    logic [CNT_W-1:0]  inodes;
    logic [PTR_W-1:0]  ibytes;
    logic [PTR_W-1:0]  tbytes;
    logic [7:0]        imask;
    logic [7:0]        dmask;
    logic [DBLK_W-1:0] dlim;
    logic [ITB_W:0]    dbase;
  } layout_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MAP_AW-1:0] raddr;
  } ram_req_t;

  // Mask that keeps the ex leading bits of the last byte of a region
  function automatic logic [7:0] pad_mask(input logic [2:0] ex);
    logic [15:0] t;
    t = 16'(BYTE_FULL) << (4'd8 - {1'b0, ex});
    if (ex == 3'd0) return BYTE_FULL;
    return t[7:0];
  endfunction

  function automatic layout_t calc_layout(input logic [ITB_W-1:0] itb,
                                          input logic [DBLK_W-1:0] db);
    layout_t     l;
    logic [17:0] inodes_w;
    logic [12:0] data_w;
    logic [17:0] ibytes_w;
    logic [17:0] dbytes_w;
    logic [17:0] tbytes_w;
    inodes_w = 18'(itb) * 18'(INODES_IN_BLOCK);
    data_w   = 13'(db) - 13'(itb) - 13'd2;
    ibytes_w = (inodes_w + 18'd7) >> 3;
    dbytes_w = (18'(data_w) + 18'd7) >> 3;
    tbytes_w = ibytes_w + dbytes_w;
    l.ok     = (itb >= ITB_MIN) && (itb <= ITB_MAX) &&
               (db >= DBLK_MIN) && (db <= DBLK_MAX) &&
               (13'(db) >= 13'(itb) + 13'd3) &&
               (inodes_w <= 18'(CNT_MAX)) &&
               (tbytes_w <= 18'(MAP_BYTES));
    l.inodes = inodes_w[CNT_W-1:0];
    l.ibytes = ibytes_w[PTR_W-1:0];
    l.tbytes = tbytes_w[PTR_W-1:0];
    l.imask  = pad_mask(inodes_w[2:0]);
    l.dmask  = pad_mask(data_w[2:0]);
    l.dlim   = db - 12'd1;
    l.dbase  = {1'b0, itb} + 8'd1;
    return l;
  endfunction

  localparam layout_t RST_LAYOUT = calc_layout(RST_ITB, RST_DBLK);

  // Position of the first set bit counted from the MSB
  function automatic logic [2:0] lead_pos(input logic [7:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = 3'(7 - k);
    end
    return p;
  endfunction

endpackage

// ===== hdl/tbfa_map_ram.sv =====
// Byte-wide bitmap store with one write port and one registered read port.
module tbfa_map_ram
  import tbfa_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/tbfa_layout.sv =====
// Region layout and validity check, registered from the configuration registers.
module tbfa_layout
  import tbfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ITB_W-1:0]  itb,
  input  logic [DBLK_W-1:0] dblk,
  output layout_t           lay
);

  layout_t lay_r;
  layout_t lay_nxt;

  assign lay_nxt = calc_layout(itb, dblk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lay_r <= RST_LAYOUT;
    end else begin
      lay_r <= lay_nxt;
    end
  end

  assign lay = lay_r;

endmodule

// ===== hdl/tbfa_ctrl.sv =====
// Sequencer: byte scan, read-modify-write and format sweep over the bitmap store.
module tbfa_ctrl
  import tbfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_granted,
  output logic [CNT_W-1:0]  out_used_inodes,
  input  layout_t           lay,
  output ram_req_t          ram_req,
  input  logic [7:0]        ram_rdata
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_FREE   = 8'b0001_0000,
    S_FMT    = 8'b0010_0000,
    S_RESP   = 8'b0100_0000
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   scan_end_r, scan_end_nxt;
  logic [PTR_W-1:0]   base_r, base_nxt;
  logic               pend_r, pend_nxt;
  logic [MAP_AW-1:0]  pend_addr_r, pend_addr_nxt;
  logic [MAP_AW-1:0]  waddr_r, waddr_nxt;
  logic [7:0]         wmask_r, wmask_nxt;
  logic [PTR_W-1:0]   fmt_ib_r, fmt_ib_nxt;
  logic [PTR_W-1:0]   fmt_tb_r, fmt_tb_nxt;
  logic [7:0]         fmt_im_r, fmt_im_nxt;
  logic [7:0]         fmt_dm_r, fmt_dm_nxt;
  logic [CNT_W-1:0]   fmt_inodes_r, fmt_inodes_nxt;
  logic [CNT_W-1:0]   free_cnt_r, free_cnt_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_granted_r, res_granted_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_granted_r, out_granted_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;

  logic [IDX_W-1:0]   rel_blk;
  logic [PTR_W-1:0]   blk_addr;
  logic [2:0]         bit_pos;
  logic [PTR_W-1:0]   rel_byte;
  logic [IDX_W-1:0]   rel_bit;
  logic [7:0]         fmt_byte;
  logic [CNT_W-1:0]   used_w;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    rel_blk  = idx_r - IDX_W'(lay.dbase);
    blk_addr = lay.ibytes + PTR_W'(rel_blk >> 3);
    bit_pos  = lead_pos(ram_rdata);
    rel_byte = PTR_W'({1'b0, pend_addr_r}) - base_r;
    rel_bit  = IDX_W'({rel_byte, bit_pos});
    if (ptr_r >= fmt_tb_r) fmt_byte = 8'h00;
    else if (ptr_r == fmt_tb_r - PTR_W'(1)) fmt_byte = fmt_dm_r;
    else if (ptr_r == fmt_ib_r - PTR_W'(1)) fmt_byte = fmt_im_r;
    else fmt_byte = BYTE_FULL;
    if (!lay.ok || (free_cnt_r > lay.inodes)) used_w = '0;
    else used_w = lay.inodes - free_cnt_r;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    ptr_nxt         = ptr_r;
    scan_end_nxt    = scan_end_r;
    base_nxt        = base_r;
    pend_nxt        = 1'b0;
    pend_addr_nxt   = pend_addr_r;
    waddr_nxt       = waddr_r;
    wmask_nxt       = wmask_r;
    fmt_ib_nxt      = fmt_ib_r;
    fmt_tb_nxt      = fmt_tb_r;
    fmt_im_nxt      = fmt_im_r;
    fmt_dm_nxt      = fmt_dm_r;
    fmt_inodes_nxt  = fmt_inodes_r;
    free_cnt_nxt    = free_cnt_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    ram_req         = '0;

    case (state_r)
      S_CLEAR, S_FMT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r[MAP_AW-1:0];
        ram_req.wdata = fmt_byte;
        if (ptr_r == PTR_W'(MAP_BYTES - 1)) begin
          ptr_nxt = '0;
          if (state_r == S_FMT) begin
            free_cnt_nxt = fmt_inodes_r;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          idx_nxt   = in_index;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_nxt  = ST_OK;
        res_granted_nxt = '0;
        if (!lay.ok) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_RESP;
        end else begin
          case (op_r)
            OP_GRAB_INODE: begin
              ptr_nxt      = '0;
              base_nxt     = '0;
              scan_end_nxt = lay.ibytes;
              state_nxt    = S_SCAN;
            end
            OP_GRAB_DATA: begin
              ptr_nxt      = lay.ibytes;
              base_nxt     = lay.ibytes;
              scan_end_nxt = lay.tbytes;
              state_nxt    = S_SCAN;
            end
            OP_FREE_INODE: begin
              if (idx_r >= IDX_W'(lay.inodes)) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_RESP;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = MAP_AW'(idx_r >> 3);
                waddr_nxt     = MAP_AW'(idx_r >> 3);
                wmask_nxt     = MSB_BIT >> idx_r[2:0];
                state_nxt     = S_FREE;
              end
            end
            OP_FREE_DATA: begin
              if ((idx_r >= lay.dlim) || (idx_r < IDX_W'(lay.dbase))) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_RESP;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = blk_addr[MAP_AW-1:0];
                waddr_nxt     = blk_addr[MAP_AW-1:0];
                wmask_nxt     = MSB_BIT >> rel_blk[2:0];
                state_nxt     = S_FREE;
              end
            end
            OP_FORMAT: begin
              fmt_ib_nxt     = lay.ibytes;
              fmt_tb_nxt     = lay.tbytes;
              fmt_im_nxt     = lay.imask;
              fmt_dm_nxt     = lay.dmask;
              fmt_inodes_nxt = lay.inodes;
              ptr_nxt        = '0;
              state_nxt      = S_FMT;
            end
            default: begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // check the byte read last cycle while the next read is issued
        if (pend_r && (ram_rdata != 8'h00)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_addr_r;
          ram_req.wdata = ram_rdata & ~(MSB_BIT >> bit_pos);
          if (op_r == OP_GRAB_DATA) begin
            res_granted_nxt = rel_bit + IDX_W'(lay.dbase);
          end else begin
            res_granted_nxt = rel_bit;
            if (free_cnt_r != '0) free_cnt_nxt = free_cnt_r - CNT_W'(1);
          end
          state_nxt = S_RESP;
        end else if (ptr_r >= scan_end_r) begin
          res_status_nxt = ST_NONE;
          state_nxt      = S_RESP;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r[MAP_AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[MAP_AW-1:0];
          ptr_nxt       = ptr_r + PTR_W'(1);
        end
      end

      S_FREE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = waddr_r;
        ram_req.wdata = ram_rdata | wmask_r;
        // count only a bit that was actually taken before
        if ((op_r == OP_FREE_INODE) && ((ram_rdata & wmask_r) == 8'h00) &&
            (free_cnt_r < CNT_MAX)) begin
          free_cnt_nxt = free_cnt_r + CNT_W'(1);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_used_nxt    = used_w;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      fmt_ib_r     <= RST_LAYOUT.ibytes;
      fmt_tb_r     <= RST_LAYOUT.tbytes;
      fmt_im_r     <= RST_LAYOUT.imask;
      fmt_dm_r     <= RST_LAYOUT.dmask;
      fmt_inodes_r <= RST_LAYOUT.inodes;
      free_cnt_r   <= RST_LAYOUT.inodes;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      fmt_ib_r     <= fmt_ib_nxt;
      fmt_tb_r     <= fmt_tb_nxt;
      fmt_im_r     <= fmt_im_nxt;
      fmt_dm_r     <= fmt_dm_nxt;
      fmt_inodes_r <= fmt_inodes_nxt;
      free_cnt_r   <= free_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    idx_r         <= idx_nxt;
    scan_end_r    <= scan_end_nxt;
    base_r        <= base_nxt;
    pend_addr_r   <= pend_addr_nxt;
    waddr_r       <= waddr_nxt;
    wmask_r       <= wmask_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_granted     = out_granted_r;
  assign out_used_inodes = out_used_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted transaction did not enter decode");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response state");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> ((state_r == S_SCAN) || (state_r == S_FREE) ||
                    (state_r == S_CLEAR) || (state_r == S_FMT)))
    else $error("bitmap written from an unexpected state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r <= scan_end_r))
    else $error("scan pointer passed the region end");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_granted_r == '0))
    else $error("failed transaction carries a granted number");

endmodule

// ===== hdl/two_region_free_bitmap_allocator.sv =====
// Top level: configuration registers, layout, sequencer and bitmap store.
//
// Usage: one input transaction carries in_op and in_index; each produces
// exactly one result (out_status, out_granted, out_used_inodes). A
// transaction moves at a rising edge with valid high and stall low.
// Configuration registers are to be written through cfg_we / cfg_index /
// cfg_wdata while the block is idle; the block itself does not enforce
// this. The new layout applies from the next transaction.
// Steps from accept to result: a free reads the bitmap byte, then writes
// it back; an invalid op, index out of range or invalid layout goes from
// decode straight to the response; a grab scans the region byte by byte up
// to the first non-empty byte, or to the region end when nothing is free;
// a format writes the whole bitmap, one bitmap byte written per cycle.
// One transaction is in work at a time; in_stall stays high until the
// result is loaded into the output register, and the next transaction is
// taken from the idle state that follows.
// A stalled result holds, and the next transaction can be accepted while it
// waits. After reset a clearing pass over every bitmap byte formats the store
// for the reset configuration; in_stall is high for its length.
module two_region_free_bitmap_allocator
  import tbfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [IDX_W-1:0]      in_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ST_W-1:0]       out_status,
  output logic [IDX_W-1:0]      out_granted,
  output logic [CNT_W-1:0]      out_used_inodes
);

  logic [ITB_W-1:0]  itb_r, itb_nxt;
  logic [DBLK_W-1:0] dblk_r, dblk_nxt;
  layout_t           lay;
  ram_req_t          ram_req;
  logic [7:0]        ram_rdata;

  always_comb begin
    itb_nxt  = itb_r;
    dblk_nxt = dblk_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ITB:  itb_nxt  = cfg_wdata[ITB_W-1:0];
        CFG_DBLK: dblk_nxt = cfg_wdata[DBLK_W-1:0];
        default:  itb_nxt  = itb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itb_r  <= RST_ITB;
      dblk_r <= RST_DBLK;
    end else begin
      itb_r  <= itb_nxt;
      dblk_r <= dblk_nxt;
    end
  end

  tbfa_layout u_layout (
    .clk   (clk),
    .rst_n (rst_n),
    .itb   (itb_r),
    .dblk  (dblk_r),
    .lay   (lay)
  );

  tbfa_map_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  tbfa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_granted     (out_granted),
    .out_used_inodes (out_used_inodes),
    .lay             (lay),
    .ram_req         (ram_req),
    .ram_rdata       (ram_rdata)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-region first-fit free bitmap allocator.
module tb_top
  import tbfa_pkg::*;
();

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 600;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int PRESSURE_ITEMS  = 40;

  // Op codes the block does not assign
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} rx_style_t;

  typedef struct {
    bit ok;
    int inodes;
    int data;
    int ibytes;
    int tbytes;
  } region_plan_t;

  typedef struct {
    status_t                status;
    logic [IDX_W-1:0]       granted;
    logic [CNT_W-1:0]       used;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op = '0;
  logic [IDX_W-1:0]      in_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ST_W-1:0]       out_status;
  logic [IDX_W-1:0]      out_granted;
  logic [CNT_W-1:0]      out_used_inodes;

  // Shadow of the block: bitmap, free inode counter and registers
  logic [7:0]    bitmap_shadow [MAP_BYTES];
  int            free_inodes;
  int            shadow_itb;
  int            shadow_dblk;
  alloc_result_t expected_allocs [$];

  int        cycle_count = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        sent_items = 0;
  int        config_writes = 0;
  int        format_count = 0;
  int        none_count = 0;
  int        range_count = 0;
  int        burst_left = 0;
  bit        steady_sender = 1'b0;
  rx_style_t stall_style = STALL_NONE;
  logic [7:0] stall_pattern = 8'h5A;
  int        hold_ticket = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  two_region_free_bitmap_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_granted     (out_granted),
    .out_used_inodes (out_used_inodes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic region_plan_t plan_regions();
    region_plan_t p;
    p = '{default: 0};
    if (shadow_itb < 1 || shadow_itb > 64) return p;
    if (shadow_dblk < 4 || shadow_dblk > 3072) return p;
    if (shadow_dblk < shadow_itb + 3) return p;
    p.inodes = shadow_itb * INODES_IN_BLOCK;
    if (p.inodes > 2047) return p;
    p.data   = shadow_dblk - shadow_itb - 2;
    p.ibytes = (p.inodes + 7) / 8;
    p.tbytes = p.ibytes + (p.data + 7) / 8;
    if (p.tbytes > MAP_BYTES) return p;
    p.ok = 1'b1;
    return p;
  endfunction

  function automatic void format_bitmap(region_plan_t p);
    int pad;
    foreach (bitmap_shadow[i]) bitmap_shadow[i] = (i < p.tbytes) ? BYTE_FULL : 8'h00;
    // clear the padding bits past the end of each region
    pad = p.inodes % 8;
    if (pad != 0) bitmap_shadow[p.ibytes - 1] &= BYTE_FULL << (8 - pad);
    pad = p.data % 8;
    if (pad != 0) bitmap_shadow[p.tbytes - 1] &= BYTE_FULL << (8 - pad);
    free_inodes = p.inodes;
  endfunction

  // First set bit from byte first_byte up, MSB first; -1 when none
  function automatic int take_first_free(int first_byte, int end_byte);
    for (int b = first_byte; b < end_byte; b++) begin
      for (int k = 7; k >= 0; k--) begin
        if (bitmap_shadow[b][k]) begin
          bitmap_shadow[b][k] = 1'b0;
          return (b - first_byte) * 8 + (7 - k);
        end
      end
    end
    return -1;
  endfunction

  function automatic void reset_shadow();
    region_plan_t p;
    shadow_itb  = int'(RST_ITB);
    shadow_dblk = int'(RST_DBLK);
    foreach (bitmap_shadow[i]) bitmap_shadow[i] = 8'h00;
    free_inodes = 0;
    p = plan_regions();
    if (p.ok) format_bitmap(p);
  endfunction

  function automatic alloc_result_t predict_alloc(logic [OP_W-1:0] op,
                                                  logic [IDX_W-1:0] idx);
    region_plan_t  p;
    alloc_result_t r;
    int            pos;
    int            ix;
    int            rel;
    p = plan_regions();
    ix = int'(idx);
    r.status  = ST_OK;
    r.granted = '0;
    r.used    = '0;
    if (!p.ok) begin
      r.status = ST_RANGE;
      range_count++;
      return r;
    end
    case (op)
      OP_GRAB_INODE: begin
        pos = take_first_free(0, p.ibytes);
        if (pos < 0) r.status = ST_NONE;
        else begin
          r.granted = IDX_W'(pos);
          if (free_inodes > 0) free_inodes--;
        end
      end
      OP_GRAB_DATA: begin
        pos = take_first_free(p.ibytes, p.tbytes);
        if (pos < 0) r.status = ST_NONE;
        else r.granted = IDX_W'(pos + 1 + shadow_itb);
      end
      OP_FREE_INODE: begin
        if (ix >= p.inodes) r.status = ST_RANGE;
        else if (!bitmap_shadow[ix / 8][7 - ix % 8]) begin
          // a double free leaves the counter alone
          bitmap_shadow[ix / 8][7 - ix % 8] = 1'b1;
          if (free_inodes < CNT_MAX) free_inodes++;
        end
      end
      OP_FREE_DATA: begin
        if (ix >= shadow_dblk - 1 || ix < 1 + shadow_itb) r.status = ST_RANGE;
        else begin
          rel = ix - 1 - shadow_itb;
          bitmap_shadow[p.ibytes + rel / 8][7 - rel % 8] = 1'b1;
        end
      end
      OP_FORMAT: begin
        format_bitmap(p);
        format_count++;
      end
      default: r.status = ST_RANGE;
    endcase
    if (r.status == ST_NONE) none_count++;
    if (r.status == ST_RANGE) range_count++;
    r.used = (free_inodes > p.inodes) ? '0 : CNT_W'(p.inodes - free_inodes);
    return r;
  endfunction

  // Receiver: long hold-off on request, otherwise the phase's stall style
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_allocs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: status %0d granted %0d used %0d",
                   results_seen, out_status, out_granted, out_used_inodes);
      end else begin
        want = expected_allocs.pop_front();
        if (out_status !== want.status || out_granted !== want.granted ||
            out_used_inodes !== want.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d granted %0d used %0d, got %0d %0d %0d",
                     results_seen, want.status, want.granted, want.used,
                     out_status, out_granted, out_used_inodes);
        end
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= idx;
    do @(posedge clk); while (in_stall);
    expected_allocs.push_back(predict_alloc(op, idx));
    sent_items++;
  endtask

  // Send in bursts with random gaps between them, no gaps for a steady sender
  task automatic paced_send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_request(op, idx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write both registers; call only with nothing in flight
  task automatic set_config(input logic [ITB_W-1:0] itb, input logic [DBLK_W-1:0] db);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ITB;
    cfg_wdata <= CFG_DATA_W'(itb);
    @(posedge clk);
    cfg_index <= CFG_DBLK;
    cfg_wdata <= db;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_itb  = int'(itb);
    shadow_dblk = int'(db);
    config_writes++;
  endtask

  task automatic test_reset_layout_ops();
    stall_style = STALL_RANDOM;
    send_request(OP_GRAB_INODE, '0);
    send_request(OP_GRAB_DATA, '0);
    send_request(OP_FREE_INODE, 12'd0);
    send_request(OP_FREE_INODE, 12'd0);
    send_request(OP_FREE_INODE, 12'd15);
    send_request(OP_FREE_INODE, 12'd16);
    send_request(OP_FREE_INODE, 12'hFFF);
    send_request(OP_FREE_DATA, 12'd2);
    send_request(OP_FREE_DATA, 12'd62);
    send_request(OP_FREE_DATA, 12'd63);
    send_request(OP_FREE_DATA, 12'd1);
    send_request(OP_SPARE_LO, 12'hA5A);
    send_request(OP_SPARE_HI, 12'h5A5);
    send_request(OP_FORMAT, '0);
    drain_results();
  endtask

  task automatic test_config_extremes();
    // smallest disk, first without a format so the old map is read as it stands
    set_config(ITB_MIN, DBLK_MIN);
    send_request(OP_GRAB_DATA, '0);
    send_request(OP_FORMAT, '0);
    send_request(OP_GRAB_DATA, '0);
    send_request(OP_GRAB_DATA, '0);
    drain_results();
    set_config(ITB_MAX, DBLK_MAX);
    send_request(OP_FORMAT, '0);
    send_request(OP_GRAB_DATA, '0);
    send_request(OP_FREE_DATA, DBLK_MAX - 12'd1);
    send_request(OP_FREE_DATA, DBLK_MAX - 12'd2);
    drain_results();
    set_config('0, RST_DBLK);
    send_request(OP_GRAB_INODE, '0);
    drain_results();
  endtask

  task automatic pick_random_config();
    int sel;
    int itb;
    int db;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      itb = $urandom_range(1, 3);
      db  = itb + $urandom_range(3, 40);
    end else if (sel < 68) begin
      itb = $urandom_range(ITB_MIN, ITB_MAX);
      db  = $urandom_range(itb + 3, DBLK_MAX);
    end else if (sel < 78) begin
      case ($urandom_range(0, 3))
        0: begin itb = int'(ITB_MAX); db = int'(DBLK_MAX); end
        1: begin itb = int'(ITB_MIN); db = int'(DBLK_MAX); end
        2: begin itb = int'(ITB_MAX); db = int'(ITB_MAX) + 3; end
        default: begin itb = int'(ITB_MIN); db = int'(DBLK_MIN); end
      endcase
    end else if (sel < 88) begin
      return;  // keep the registers, map stays as it is
    end else begin
      case ($urandom_range(0, 3))
        0: begin itb = 0; db = $urandom_range(DBLK_MIN, DBLK_MAX); end
        1: begin
          itb = $urandom_range(ITB_MAX + 1, 127);
          db  = $urandom_range(DBLK_MIN, DBLK_MAX);
        end
        2: begin
          itb = $urandom_range(ITB_MIN, ITB_MAX);
          db  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(DBLK_MAX + 1, 4095);
        end
        default: begin itb = $urandom_range(ITB_MIN, ITB_MAX); db = itb + 2; end
      endcase
    end
    set_config(ITB_W'(itb), DBLK_W'(db));
  endtask

  task automatic test_random_phases();
    region_plan_t     p;
    int               r;
    int               grab_pct;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      pick_random_config();
      stall_style   = rx_style_t'($urandom_range(0, 2));
      stall_pattern = 8'($urandom) & 8'h77;
      steady_sender = ($urandom_range(0, 3) == 0);
      burst_left    = 0;
      grab_pct      = $urandom_range(20, 80);
      if ($urandom_range(0, 9) < 7) send_request(OP_FORMAT, IDX_W'($urandom));
      p = plan_regions();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom);
        if (r < 2) op = OP_FORMAT;
        else if (r < 5) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (r < 5 + grab_pct * 95 / 100)
          op = $urandom_range(0, 1) ? OP_GRAB_DATA : OP_GRAB_INODE;
        else if ($urandom_range(0, 1)) begin
          op = OP_FREE_INODE;
          if (p.ok && $urandom_range(0, 6) != 0) idx = IDX_W'($urandom_range(0, p.inodes - 1));
        end else begin
          op = OP_FREE_DATA;
          if (p.ok && $urandom_range(0, 6) != 0)
            idx = IDX_W'($urandom_range(shadow_itb + 1, shadow_dblk - 2));
        end
        paced_send(op, idx);
      end
    end
    drain_results();
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    set_config(7'd2, 12'd40);
    stall_style = STALL_NONE;
    send_request(OP_FORMAT, '0);
    drain_results();
    hold_ticket++;
    for (int n = 0; n < PRESSURE_ITEMS; n++) begin
      if (n % 2 == 0) send_request(OP_GRAB_INODE, '0);
      else send_request(OP_FREE_INODE, IDX_W'($urandom_range(0, 31)));
    end
    drain_results();
  endtask

  task automatic finish_run();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transactions across %0d register settings, %0d of them formats.",
             sent_items, config_writes, format_count);
    $display("Grabs with no free bit: %0d; range or layout rejections: %0d; mismatches: %0d.",
             none_count, range_count, mismatches);
    if (mismatches == 0 && expected_allocs.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_layout_ops();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    finish_run();
  end

endmodule
